// File: rtl/core/mulw_pkg.sv
// Shared definitions for the modem URC line watcher: request codes, character
// constants and the two fixed header texts. No dependencies.
package mulw_pkg;

  // Default number of bytes in the line store.
  localparam int LINE_DEPTH_DEFAULT = 256;

  // Request codes carried on func.
  typedef enum logic [1:0] {
    FUNC_RECV   = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_REINIT = 2'd3
  } func_t;

  localparam int HEADER_LEN        = 9;
  localparam int STATUS_PREFIX_LEN = 12;

  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_Q    = 8'h51;
  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_TWO  = 8'h32;
  localparam logic [7:0] CHAR_THREE = 8'h33;

  // Source of the read byte of a result.
  typedef enum logic [1:0] {
    RD_ZERO   = 2'd0,
    RD_MEM    = 2'd1,
    RD_HEADER = 2'd2
  } rd_sel_t;

  // Characters of the receive header "+QMTRECV:".
  function automatic logic [7:0] header_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h2B;  // '+'
      4'd1:    c = 8'h51;  // 'Q'
      4'd2:    c = 8'h4D;  // 'M'
      4'd3:    c = 8'h54;  // 'T'
      4'd4:    c = 8'h52;  // 'R'
      4'd5:    c = 8'h45;  // 'E'
      4'd6:    c = 8'h43;  // 'C'
      4'd7:    c = 8'h56;  // 'V'
      4'd8:    c = 8'h3A;  // ':'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of the status prefix "+QMTSTAT: 0,".
  function automatic logic [7:0] status_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h2B;  // '+'
      4'd1:    c = 8'h51;  // 'Q'
      4'd2:    c = 8'h4D;  // 'M'
      4'd3:    c = 8'h54;  // 'T'
      4'd4:    c = 8'h53;  // 'S'
      4'd5:    c = 8'h54;  // 'T'
      4'd6:    c = 8'h41;  // 'A'
      4'd7:    c = 8'h54;  // 'T'
      4'd8:    c = 8'h3A;  // ':'
      4'd9:    c = 8'h20;  // ' '
      4'd10:   c = 8'h30;  // '0'
      4'd11:   c = 8'h2C;  // ','
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/mulw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mulw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/modem_urc_line_watcher.sv
// Modem URC line watcher: top level. Keeps the current receive line in a RAM.
// Depends on mulw_pkg and mulw_ram.
//
// Usage: requests arrive on req_valid/req_stall with func, byte_in and
// read_index; each accepted request gives exactly one result on
// res_valid/res_stall. func selects receive byte, clear line, read line byte
// or reinitialise. Each result carries the line length, the data ready and
// disconnected flags, the message count and the header match progress as they
// stand after the request, and for a read the line byte (zero past the end).
// Results pass the middle stage, then the output register. While req_stall
// is low a request is accepted every cycle; the line RAM takes at most one
// write or read per request, flags and counters update on accept: nothing repeats.
// When the receiver stalls, the result stays in the output register and one
// further result waits in the stage behind it, whose RAM read data is held;
// req_stall then rises until the output moves on.
// Reset clears the length, flags, count and match progress at once; the RAM
// is not cleared, as only positions written since the line restarted are
// ever read.
module modem_urc_line_watcher
  import mulw_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  byte_in,
  input  logic [7:0]  read_index,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  line_length,
  output logic        data_ready,
  output logic        disconnected,
  output logic [31:0] message_count,
  output logic [7:0]  read_byte,
  output logic [3:0]  match_progress
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] FILL_MAX     = AW'(LINE_DEPTH - 1);
  localparam logic [AW-1:0] CODE_POS     = AW'(STATUS_PREFIX_LEN);
  localparam logic [AW-1:0] DISC_MIN_POS = AW'(STATUS_PREFIX_LEN + 1);
  localparam logic [AW-1:0] READY_MIN_POS = AW'(2);
  localparam logic [AW-1:0] HEADER_FILL  = AW'(HEADER_LEN);
  localparam logic [3:0]    HEADER_LAST  = 4'(HEADER_LEN - 1);

  // Watcher state.
  logic [AW-1:0] fill;
  logic [AW-1:0] fill_next;
  logic [3:0]    pos;
  logic [3:0]    pos_next;
  logic          ready;
  logic          ready_next;
  logic          lost;
  logic          lost_next;
  logic [31:0]   count;
  logic [31:0]   count_next;
  logic [7:0]    lead;
  logic [7:0]    lead_next;
  logic [7:0]    second;
  logic [7:0]    second_next;
  logic          prefix_ok;
  logic          prefix_ok_next;
  logic          code_ok;
  logic          code_ok_next;
  // The first positions of the line read as the header text after a header.
  logic          overlay;
  logic          overlay_next;

  // Middle stage, waiting for the RAM read data.
  logic          s1_valid;
  logic [AW-1:0] s1_fill;
  logic          s1_ready;
  logic          s1_lost;
  logic [31:0]   s1_count;
  logic [3:0]    s1_pos;
  rd_sel_t       s1_sel;
  rd_sel_t       sel_next;
  logic [7:0]    s1_hdr;

  logic accept;
  logic s1_adv;
  logic hdr_hit;
  logic restart;
  logic [AW-1:0] wpos;
  logic wr_en;
  logic rd_en;
  logic [7:0] mem_rd;
  func_t f;

  assign f       = func_t'(func);
  assign s1_adv  = !res_valid || !res_stall;
  assign req_stall = s1_valid && !s1_adv;
  assign accept  = req_valid && !req_stall;
  assign hdr_hit = (byte_in == header_char(pos));
  assign restart = hdr_hit ? (pos == 4'd0) : (byte_in == CHAR_PLUS);
  assign wpos    = restart ? '0 : fill;
  assign rd_en   = accept && (f == FUNC_READ);

  // Next state for one request.
  always_comb begin
    fill_next      = fill;
    pos_next       = pos;
    ready_next     = ready;
    lost_next      = lost;
    count_next     = count;
    lead_next      = lead;
    second_next    = second;
    prefix_ok_next = prefix_ok;
    code_ok_next   = code_ok;
    overlay_next   = overlay;
    sel_next       = RD_ZERO;
    wr_en          = 1'b0;
    case (f)
      FUNC_RECV: begin
        if (hdr_hit && pos == HEADER_LAST) begin
          // Header complete: the line becomes the header text itself.
          fill_next      = HEADER_FILL;
          pos_next       = 4'd0;
          count_next     = count + 32'd1;
          ready_next     = 1'b0;
          overlay_next   = 1'b1;
          lead_next      = CHAR_PLUS;
          second_next    = CHAR_Q;
          prefix_ok_next = 1'b0;
          code_ok_next   = 1'b0;
        end else begin
          if (hdr_hit) begin
            pos_next = pos + 4'd1;
          end else if (byte_in == CHAR_PLUS) begin
            pos_next = 4'd1;
          end else begin
            pos_next = 4'd0;
          end
          if (restart) begin
            overlay_next = 1'b0;
          end
          if (wpos < FILL_MAX) begin
            wr_en     = 1'b1;
            fill_next = wpos + AW'(1);
            // Track the characters that decide the line-end checks.
            if (wpos == '0) begin
              lead_next      = byte_in;
              prefix_ok_next = (byte_in == status_char(4'd0));
            end else if (wpos < CODE_POS) begin
              prefix_ok_next = prefix_ok && (byte_in == status_char(wpos[3:0]));
            end
            if (wpos == AW'(1)) begin
              second_next = byte_in;
            end
            if (wpos == CODE_POS) begin
              code_ok_next = (byte_in == CHAR_ONE) || (byte_in == CHAR_TWO) ||
                             (byte_in == CHAR_THREE);
            end
            if (byte_in == CHAR_NL) begin
              if (wpos >= READY_MIN_POS && lead == CHAR_PLUS && second == CHAR_Q) begin
                ready_next = 1'b1;
              end
              if (wpos >= DISC_MIN_POS && prefix_ok && code_ok) begin
                lost_next = 1'b1;
              end
            end
          end else begin
            // Line full: drop the whole line.
            fill_next    = '0;
            overlay_next = 1'b0;
          end
        end
      end
      FUNC_CLEAR: begin
        fill_next    = '0;
        overlay_next = 1'b0;
      end
      FUNC_READ: begin
        if (CW'(read_index) < CW'(fill)) begin
          if (overlay && read_index < 8'(HEADER_LEN)) begin
            sel_next = RD_HEADER;
          end else begin
            sel_next = RD_MEM;
          end
        end
      end
      default: begin
        fill_next    = '0;
        overlay_next = 1'b0;
        ready_next   = 1'b0;
        count_next   = '0;
        pos_next     = 4'd0;
      end
    endcase
  end

  // Watcher state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      pos       <= 4'd0;
      ready     <= 1'b0;
      lost      <= 1'b0;
      count     <= '0;
      lead      <= '0;
      second    <= '0;
      prefix_ok <= 1'b0;
      code_ok   <= 1'b0;
      overlay   <= 1'b0;
    end else if (accept) begin
      fill      <= fill_next;
      pos       <= pos_next;
      ready     <= ready_next;
      lost      <= lost_next;
      count     <= count_next;
      lead      <= lead_next;
      second    <= second_next;
      prefix_ok <= prefix_ok_next;
      code_ok   <= code_ok_next;
      overlay   <= overlay_next;
    end
  end

  // Line store.
  mulw_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (wpos),
    .wr_data (byte_in),
    .rd_en   (rd_en),
    .rd_addr (AW'(read_index)),
    .rd_data (mem_rd)
  );

  // Middle stage: holds the result while the RAM read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv || !s1_valid) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_fill  <= fill_next;
      s1_ready <= ready_next;
      s1_lost  <= lost_next;
      s1_count <= count_next;
      s1_pos   <= pos_next;
      s1_sel   <= sel_next;
      s1_hdr   <= header_char(read_index[3:0]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      line_length    <= 8'(s1_fill);
      data_ready     <= s1_ready;
      disconnected   <= s1_lost;
      message_count  <= s1_count;
      match_progress <= s1_pos;
      case (s1_sel)
        RD_MEM:    read_byte <= mem_rd;
        RD_HEADER: read_byte <= s1_hdr;
        default:   read_byte <= 8'd0;
      endcase
    end
  end

endmodule
